@@ hdl/assert_macros.svh @@
// Assertion macros used by the checker arpc_checker.
// Depends on nothing; each macro expands to one labeled concurrent assertion.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, off while reset is held
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("%m: implication failed");

// next-cycle implication, off while reset is held
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("%m: next-cycle check failed");

`endif

@@ hdl/arpc_pkg.sv @@
// Package for the ARP resolution cache: sizes, codes and the queued item type.
// No dependencies; imported by every module of the block.
package arpc_pkg;

	localparam int ENTRIES = 16;
	localparam int QDEPTH  = 2;
	localparam int QPTR_W  = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
	localparam int QCNT_W  = $clog2(QDEPTH + 1);

	localparam logic [1:0] FN_LOOKUP = 2'd0;
	localparam logic [1:0] FN_LEARN  = 2'd1;
	localparam logic [1:0] FN_ARP    = 2'd2;
	localparam logic [1:0] FN_FRAME  = 2'd3;

	localparam logic [1:0] CFG_OWN_IP   = 2'd0;
	localparam logic [1:0] CFG_OWN_MAC  = 2'd1;
	localparam logic [1:0] CFG_MASK     = 2'd2;
	localparam logic [1:0] CFG_GW_IP    = 2'd3;

	localparam logic [15:0] OP_REQUEST = 16'h0100;
	localparam logic [15:0] OP_REPLY   = 16'h0200;

	localparam logic [2:0] KIND_NONE   = 3'd0;
	localparam logic [2:0] KIND_OWN    = 3'd1;
	localparam logic [2:0] KIND_BCAST  = 3'd2;
	localparam logic [2:0] KIND_GW     = 3'd3;
	localparam logic [2:0] KIND_TABLE  = 3'd4;
	localparam logic [2:0] KIND_OFFNET = 3'd5;

	localparam logic [31:0] IP_BCAST     = 32'hFFFF_FFFF;
	localparam logic [47:0] MAC_BCAST    = 48'hFFFF_FFFF_FFFF;
	localparam logic [7:0]  LOW_BYTE_ALL = 8'hFF;

	// where peer_ip lands in the resolve order, as far as config alone decides
	typedef enum logic [2:0] {
		PRE_OWN,
		PRE_BCAST,
		PRE_GW,
		PRE_SUB,
		PRE_OFF
	} pre_t;

	typedef enum logic [2:0] {
		ACT_NONE,
		ACT_LOOKUP,
		ACT_LEARN,       // learn, ok reports the outcome
		ACT_LEARN_QUIET, // learn as a side effect, ok already set
		ACT_SET_GW
	} act_t;

	typedef enum logic {
		BK_CMP,
		BK_WB
	} bk_state_t;

	typedef struct packed {
		act_t        act;
		pre_t        pre;
		logic [47:0] fixed_mac;
		logic [31:0] peer_ip;
		logic [47:0] peer_mac;
		logic        ok;
		logic        rsend;
	} item_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

endpackage

@@ hdl/arpc_front.sv @@
// Front end: configuration registers, input acceptance and item classification.
// Depends on arpc_pkg; pushes classified items into arpc_queue.
module arpc_front
	import arpc_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [47:0] cfg_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  func,
	input  logic [31:0] peer_ip,
	input  logic [47:0] peer_mac,
	input  logic [31:0] dest_ip,
	input  logic [15:0] arp_opcode,
	input  q_stat_t     q_stat,
	output logic        push,
	output item_t       push_item
);

	logic [31:0] own_ip_q;
	logic [47:0] own_mac_q;
	logic [31:0] mask_q;
	logic [31:0] gw_ip_q;
	logic        on_sub;
	logic        dest_own;
	logic        dest_ff;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			own_ip_q  <= '0;
			own_mac_q <= '0;
			mask_q    <= '0;
			gw_ip_q   <= '0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_OWN_IP:  own_ip_q  <= cfg_data[31:0];
				CFG_OWN_MAC: own_mac_q <= cfg_data;
				CFG_MASK:    mask_q    <= cfg_data[31:0];
				CFG_GW_IP:   gw_ip_q   <= cfg_data[31:0];
				default: ;
			endcase
		end
	end

	assign in_ready = !q_stat.full;
	assign push     = in_valid && in_ready;

	assign on_sub   = ((peer_ip ^ own_ip_q) & mask_q) == 32'd0;
	assign dest_own = dest_ip == own_ip_q;
	assign dest_ff  = dest_ip[7:0] == LOW_BYTE_ALL;

	always_comb begin
		push_item          = '0;
		push_item.peer_ip  = peer_ip;
		push_item.peer_mac = peer_mac;
		push_item.act      = ACT_NONE;

		if (peer_ip == own_ip_q)
			push_item.pre = PRE_OWN;
		else if (peer_ip == IP_BCAST)
			push_item.pre = PRE_BCAST;
		else if (peer_ip == gw_ip_q)
			push_item.pre = PRE_GW;
		else if (on_sub)
			push_item.pre = PRE_SUB;
		else
			push_item.pre = PRE_OFF;
		push_item.fixed_mac = (push_item.pre == PRE_OWN) ? own_mac_q : MAC_BCAST;

		unique case (func)
			FN_LOOKUP: begin
				push_item.act = ACT_LOOKUP;
			end
			FN_LEARN: begin
				push_item.act = ACT_LEARN;
			end
			FN_ARP: begin
				push_item.ok = 1'b1;
				if (arp_opcode == OP_REQUEST) begin
					if (dest_own) begin
						push_item.rsend = 1'b1;
						if (on_sub)
							push_item.act = ACT_LEARN_QUIET;
					end
				end else if (arp_opcode == OP_REPLY) begin
					if (peer_ip == gw_ip_q)
						push_item.act = ACT_SET_GW;
					else if (on_sub && dest_own)
						push_item.act = ACT_LEARN_QUIET;
				end
			end
			FN_FRAME: begin
				if (dest_own || dest_ff) begin
					push_item.ok = 1'b1;
					if (on_sub && peer_mac != MAC_BCAST && dest_own)
						push_item.act = ACT_LEARN_QUIET;
				end
			end
			default: ;
		endcase
	end

endmodule

@@ hdl/arpc_queue.sv @@
// Short FIFO of classified items between front and back end.
// Depends on arpc_pkg for item_t, q_stat_t and the depth.
module arpc_queue
	import arpc_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    push,
	input  item_t   push_item,
	input  logic    pop,
	output item_t   head,
	output q_stat_t q_stat
);

	item_t             mem_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;

	localparam logic [QPTR_W-1:0] PTR_LAST = QPTR_W'(QDEPTH - 1);
	localparam logic [QPTR_W-1:0] PTR_ONE  = QPTR_W'(1);
	localparam logic [QCNT_W-1:0] CNT_FULL = QCNT_W'(QDEPTH);
	localparam logic [QCNT_W-1:0] CNT_ONE  = QCNT_W'(1);

	assign head         = mem_q[rd_ptr_q];
	assign q_stat.full  = count_q == CNT_FULL;
	assign q_stat.empty = count_q == '0;

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= push_item;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + PTR_ONE;
			if (pop)
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + PTR_ONE;
			if (push && !pop)
				count_q <= count_q + CNT_ONE;
			else if (pop && !push)
				count_q <= count_q - CNT_ONE;
		end
	end

endmodule

@@ hdl/arpc_back.sv @@
// Back end: entry table, gateway entry, compare and write-back sequencer,
// output register. Depends on arpc_pkg; pops items from arpc_queue.
module arpc_back
	import arpc_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  item_t       head,
	input  q_stat_t     q_stat,
	output logic        pop,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        found,
	output logic [47:0] result_mac,
	output logic [2:0]  source_kind,
	output logic        ok,
	output logic        reply_send,
	output logic [47:0] reply_mac,
	output logic [31:0] reply_ip
);

	localparam logic [ENTRIES-1:0] ONE_HOT_LSB = ENTRIES'(1);

	bk_state_t          state_q, state_d;
	logic [31:0]        entry_ip_q  [ENTRIES];
	logic [47:0]        entry_mac_q [ENTRIES];
	logic [ENTRIES-1:0] entry_valid_q;
	logic [47:0]        gw_mac_q;
	logic               gw_valid_q;

	item_t              item_s2;
	logic [ENTRIES-1:0] hit_s2;
	logic [ENTRIES-1:0] free_s2;

	logic [ENTRIES-1:0] hit_now;
	logic [ENTRIES-1:0] hit_oh;
	logic [ENTRIES-1:0] free_oh;
	logic [47:0]        hit_mac;
	logic [2:0]         res_kind;
	logic [47:0]        res_mac;
	logic               resolved;
	logic               any_free;
	logic               is_learn;
	logic               do_write;
	logic               load_out;

	logic               out_valid_q;
	logic               found_q;
	logic [47:0]        result_mac_q;
	logic [2:0]         source_kind_q;
	logic               ok_q;
	logic               reply_send_q;
	logic [47:0]        reply_mac_q;
	logic [31:0]        reply_ip_q;

	// parallel compare against the queue head
	always_comb begin
		for (int i = 0; i < ENTRIES; i++)
			hit_now[i] = entry_valid_q[i] && (entry_ip_q[i] == head.peer_ip);
	end

	// lowest set bit picks the first matching and the first free slot
	assign hit_oh   = hit_s2 & (~hit_s2 + ONE_HOT_LSB);
	assign free_oh  = free_s2 & (~free_s2 + ONE_HOT_LSB);
	assign any_free = |free_s2;

	always_comb begin
		hit_mac = '0;
		for (int i = 0; i < ENTRIES; i++)
			hit_mac = hit_mac | (entry_mac_q[i] & {48{hit_oh[i]}});
	end

	always_comb begin
		res_kind = KIND_NONE;
		res_mac  = '0;
		case (item_s2.pre) inside
			PRE_OWN, PRE_BCAST: begin
				res_kind = (item_s2.pre == PRE_OWN) ? KIND_OWN : KIND_BCAST;
				res_mac  = item_s2.fixed_mac;
			end
			PRE_GW: begin
				if (gw_valid_q) begin
					res_kind = KIND_GW;
					res_mac  = gw_mac_q;
				end
			end
			PRE_SUB: begin
				if (|hit_s2) begin
					res_kind = KIND_TABLE;
					res_mac  = hit_mac;
				end
			end
			PRE_OFF: begin
				res_kind = KIND_OFFNET;
				res_mac  = gw_mac_q;
			end
			default: ;
		endcase
	end

	assign resolved = res_kind != KIND_NONE;
	assign is_learn = (item_s2.act == ACT_LEARN) || (item_s2.act == ACT_LEARN_QUIET);

	// sequencer: compare cycle, then write-back into the output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= BK_CMP;
		else
			state_q <= state_d;
	end

	always_comb begin
		state_d  = state_q;
		pop      = 1'b0;
		load_out = 1'b0;
		unique case (state_q)
			BK_CMP: begin
				if (!q_stat.empty) begin
					pop     = 1'b1;
					state_d = BK_WB;
				end
			end
			BK_WB: begin
				if (!out_valid_q || out_ready) begin
					load_out = 1'b1;
					state_d  = BK_CMP;
				end
			end
			default: state_d = BK_CMP;
		endcase
	end

	assign do_write = load_out && is_learn && !resolved && any_free;

	always_ff @(posedge clk) begin
		if (pop) begin
			item_s2 <= head;
			hit_s2  <= hit_now;
			free_s2 <= ~entry_valid_q;
		end
		for (int i = 0; i < ENTRIES; i++) begin
			if (do_write && free_oh[i]) begin
				entry_ip_q[i]  <= item_s2.peer_ip;
				entry_mac_q[i] <= item_s2.peer_mac;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_valid_q <= '0;
			gw_mac_q      <= '0;
			gw_valid_q    <= 1'b0;
		end else begin
			if (do_write)
				entry_valid_q <= entry_valid_q | free_oh;
			if (load_out && item_s2.act == ACT_SET_GW) begin
				gw_mac_q   <= item_s2.peer_mac;
				gw_valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (load_out)
			out_valid_q <= 1'b1;
		else if (out_ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			if (item_s2.act == ACT_LOOKUP) begin
				found_q       <= resolved;
				result_mac_q  <= res_mac;
				source_kind_q <= res_kind;
			end else begin
				found_q       <= 1'b0;
				result_mac_q  <= '0;
				source_kind_q <= KIND_NONE;
			end
			ok_q         <= item_s2.ok ||
				(item_s2.act == ACT_LEARN && (resolved || any_free));
			reply_send_q <= item_s2.rsend;
			reply_mac_q  <= item_s2.rsend ? item_s2.peer_mac : '0;
			reply_ip_q   <= item_s2.rsend ? item_s2.peer_ip : '0;
		end
	end

	assign out_valid   = out_valid_q;
	assign found       = found_q;
	assign result_mac  = result_mac_q;
	assign source_kind = source_kind_q;
	assign ok          = ok_q;
	assign reply_send  = reply_send_q;
	assign reply_mac   = reply_mac_q;
	assign reply_ip    = reply_ip_q;

endmodule

@@ hdl/arp_resolution_cache.sv @@
// ARP resolution cache, top level: front end, item queue and back end.
// The back end takes one item from the queue at a time: a compare state, then a
// write-back state on the shared entry table that waits while a held result is
// not yet taken; a 2-entry queue absorbs bursts.
// Reset clears config registers, entry valid bits and the gateway entry at once.
// Depends on arpc_pkg, arpc_front, arpc_queue and arpc_back.
module arp_resolution_cache
	import arpc_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [47:0] cfg_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  func,
	input  logic [31:0] peer_ip,
	input  logic [47:0] peer_mac,
	input  logic [31:0] dest_ip,
	input  logic [15:0] arp_opcode,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        found,
	output logic [47:0] result_mac,
	output logic [2:0]  source_kind,
	output logic        ok,
	output logic        reply_send,
	output logic [47:0] reply_mac,
	output logic [31:0] reply_ip
);

	q_stat_t q_stat;
	logic    push;
	item_t   push_item;
	logic    pop;
	item_t   head;

	arpc_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.func       (func),
		.peer_ip    (peer_ip),
		.peer_mac   (peer_mac),
		.dest_ip    (dest_ip),
		.arp_opcode (arp_opcode),
		.q_stat     (q_stat),
		.push       (push),
		.push_item  (push_item)
	);

	arpc_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.pop       (pop),
		.head      (head),
		.q_stat    (q_stat)
	);

	arpc_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.head        (head),
		.q_stat      (q_stat),
		.pop         (pop),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.found       (found),
		.result_mac  (result_mac),
		.source_kind (source_kind),
		.ok          (ok),
		.reply_send  (reply_send),
		.reply_mac   (reply_mac),
		.reply_ip    (reply_ip)
	);

endmodule

@@ hdl/arpc_checker.sv @@
// Port-level checker for the ARP resolution cache, bound to the top level.
// Depends on arpc_pkg and assert_macros.svh.
`include "assert_macros.svh"

module arpc_checker
	import arpc_pkg::*;
(
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_ready,
	input logic        found,
	input logic [47:0] result_mac,
	input logic [2:0]  source_kind,
	input logic        reply_send,
	input logic [47:0] reply_mac,
	input logic [31:0] reply_ip
);

	// a stalled result holds
	`ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(result_mac) && $stable(source_kind) && $stable(reply_ip))

	`ASSERT_IMPLIES(a_found_kind, clk, arst_n, out_valid, found == (source_kind != KIND_NONE))

	`ASSERT_IMPLIES(a_miss_zero, clk, arst_n, out_valid && !found, result_mac == 48'd0)

	`ASSERT_IMPLIES(a_no_reply_zero, clk, arst_n, out_valid && !reply_send, reply_mac == 48'd0 && reply_ip == 32'd0)

endmodule

bind arp_resolution_cache arpc_checker u_arpc_checker (.*);
